// ----- src/assert_macros.svh -----
// Assertion macros shared by the RTL of the stream decompressor.
// No dependencies; the checks compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RSD_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("rsd assertion failed");
`define RSD_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("rsd forbidden condition seen");
`else
`define RSD_ASSERT(lbl, clk, rst, prop)
`define RSD_NEVER(lbl, clk, rst, cond)
`endif
`endif

// ----- src/rsd_pkg.sv -----
// Types, codes and command decode for the RefPack stream decompressor.
// No dependencies.
`default_nettype none
package rsd_pkg;

   typedef enum logic [2:0] {
      PH_FLAG, PH_MAGIC, PH_PSIZE, PH_USIZE, PH_CMD, PH_CMDMORE, PH_LIT
   } phase_type;

   typedef enum logic [2:0] {
      ST_RUN, ST_DONE, ST_HDR, ST_SIZE, ST_DIST, ST_OVER, ST_TRUNC, ST_REFUSED
   } status_type;

   localparam logic [1:0] CSR_PACKED_LENGTH  = 2'd0;
   localparam logic [1:0] CSR_EXPECTED_CHECK = 2'd1;
   localparam logic [1:0] CSR_EXPECTED_SIZE  = 2'd2;

   localparam logic [7:0]  MAGIC_BYTE = 8'hFB;
   localparam logic [7:0]  FLAG_MASK  = 8'h7E;
   localparam logic [7:0]  FLAG_BASE  = 8'h10;
   localparam logic [24:0] MIN_PACKED = 25'd5;

   typedef struct packed {
      logic [7:0]  lits;
      logic [10:0] copy;
      logic [17:0] offset;
      logic        term;
   } cmd_dec_type;

   function automatic logic [2:0] cmd_len(input logic [7:0] b0);
      logic [2:0] len;
      if (b0 < 8'h80)      len = 3'd2;
      else if (b0 < 8'hC0) len = 3'd3;
      else if (b0 < 8'hE0) len = 3'd4;
      else                 len = 3'd1;
      return len;
   endfunction

   // flags[0]: 4-byte sizes, flags[1]: packed size present
   function automatic logic [3:0] hdr_len(input logic [1:0] flags);
      logic [3:0] fb;
      fb = flags[0] ? 4'd4 : 4'd3;
      return flags[1] ? 4'd2 + (fb << 1) : 4'd2 + fb;
   endfunction

   function automatic cmd_dec_type cmd_decode(input logic [7:0] b0, input logic [7:0] b1,
                                              input logic [7:0] b2, input logic [7:0] b3);
      cmd_dec_type d;
      d = '0;
      if (b0 < 8'h80) begin
         d.lits = {6'd0, b0[1:0]};
         d.copy = 11'(b0[4:2]) + 11'd3;
         d.offset = {8'd0, b0[6:5], b1} + 18'd1;
      end else if (b0 < 8'hC0) begin
         d.lits = {6'd0, b1[7:6]};
         d.copy = 11'(b0[5:0]) + 11'd4;
         d.offset = {4'd0, b1[5:0], b2} + 18'd1;
      end else if (b0 < 8'hE0) begin
         d.lits = {6'd0, b0[1:0]};
         d.copy = {1'b0, b0[3:2], b3} + 11'd5;
         d.offset = {1'b0, b0[4], b1, b2} + 18'd1;
      end else if (b0 < 8'hFC) begin
         d.lits = {1'b0, b0[4:0], 2'b00} + 8'd4;
      end else begin
         d.lits = {6'd0, b0[1:0]};
         d.term = 1'b1;
      end
      return d;
   endfunction

endpackage
`default_nettype wire

// ----- src/refpack_stream_decompressor.sv -----
// Top level of the RefPack (QFS) LZ77 stream decompressor: header check, command
// decode and back-reference copy out of a history RAM. Uses rsd_pkg, assert_macros.svh.
//
//   channel | dir | handshake             | payload
//   req     | in  | req_valid/req_ready   | req_cmd, req_in_byte
//   rsp     | out | rsp_valid/rsp_ready   | has_byte, out_byte, copy_pending, status,
//           |     |                       | bytes_consumed
//   csr     | in  | csr_valid/csr_ready   | csr_index, csr_wdata
//
// One item per cycle unless the output stalls. An item updates the decoder at its
// accept edge and reads the history RAM there; its result moves from the middle stage
// into the output register when it is free. The history write happens as the result
// leaves the middle stage; a copy reading that same entry takes the byte by forwarding.
// Reset clears control state only; the history RAM needs no clearing.
// req_ready drops only while the output register is full and not taken.
`default_nettype none
`include "assert_macros.svh"
module refpack_stream_decompressor #(
   parameter int HISTORY_BYTES    = 131072,
   parameter int MAX_OUTPUT_BYTES = 16777216,
   parameter int MAX_INPUT_BYTES  = 16777216
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_cmd,
   input  wire logic [7:0]  req_in_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_has_byte,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_copy_pending,
   output logic [2:0]       rsp_status,
   output logic [24:0]      rsp_bytes_consumed,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [24:0] csr_wdata
);

   localparam int HB = $clog2(HISTORY_BYTES);
   localparam int DW = HB + 1;
   localparam int PW = $clog2(MAX_OUTPUT_BYTES) + 1;
   localparam logic [DW-1:0] HIST_SIZE = DW'(HISTORY_BYTES);
   localparam logic [HB-1:0] HIST_LAST = HB'(HISTORY_BYTES - 1);

   // configuration
   logic [24:0] plen_ff, exp_size_ff;
   logic        exp_chk_ff;

   // decoder state
   rsd_pkg::phase_type  phase_ff, phase_in;
   rsd_pkg::status_type status_ff, status_in;
   logic [24:0]   consumed_ff, consumed_in;
   logic [PW-1:0] produced_ff, produced_in;
   logic [PW-1:0] target_ff, target_in;
   logic [31:0]   acc_ff, acc_in;
   logic [1:0]    hflags_ff, hflags_in;
   logic [23:0]   cmdb_ff, cmdb_in;
   logic [2:0]    bcnt_ff, bcnt_in;
   logic [7:0]    lits_ff, lits_in;
   logic [10:0]   copy_ff, copy_in;
   logic [17:0]   dist_ff, dist_in;
   logic          term_ff, term_in;
   logic [HB-1:0] wp_ff, wp_in;

   // middle stage
   logic          s1_valid_ff, s1_has_ff, s1_copy_ff, s1_fwd_ff, s1_pend_ff;
   logic [7:0]    s1_lit_ff, s1_fwd_byte_ff;
   logic [HB-1:0] s1_waddr_ff;
   logic [2:0]    s1_status_ff;
   logic [24:0]   s1_cons_ff;
   logic [7:0]    s1_byte;
   logic          s1_adv;

   // history RAM
   logic [7:0]    hist_mem [HISTORY_BYTES];
   logic [7:0]    mem_q_ff;
   logic          rd_en;
   logic [HB-1:0] src_addr;

   logic        accept;
   logic        step_has, step_copy, step_refused, step_pend;
   logic [2:0]  step_status;
   logic        copying;
   logic [DW-1:0] dmod, wpx;
   logic [HB-1:0] wp_inc;

   // decode helpers
   logic          fail_en;
   rsd_pkg::status_type fail_code;
   logic          cmpl_en, eoc_en, eoc_term;
   logic [PW-1:0] eoc_prod;
   logic [7:0]    cb0, cb1, cb2, cb3, sel_b0;
   rsd_pkg::cmd_dec_type dec;
   logic [31:0]   acc_n;
   logic [2:0]    bc_n, fb, len;
   logic [3:0]    hl;
   logic [25:0]   cons1;

   assign accept    = req_valid && req_ready;
   assign s1_adv    = s1_valid_ff && (!rsp_valid || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_adv;
   assign csr_ready = 1'b1;
   assign copying   = (status_ff == rsd_pkg::ST_RUN) && (phase_ff == rsd_pkg::PH_CMD) &&
                      (copy_ff != 11'd0);

   // copy source: write pointer minus distance, modulo the window
   assign dmod     = (DW'(dist_ff) >= HIST_SIZE) ? DW'(dist_ff) - HIST_SIZE : DW'(dist_ff);
   assign wpx      = DW'(wp_ff);
   assign src_addr = (wpx >= dmod) ? HB'(wpx - dmod) : HB'(wpx + HIST_SIZE - dmod);
   assign wp_inc   = (wp_ff == HIST_LAST) ? '0 : wp_ff + 1'b1;

   // next state of the decoder
   always_comb begin
      phase_in = phase_ff;   status_in = status_ff;  consumed_in = consumed_ff;
      produced_in = produced_ff; target_in = target_ff; acc_in = acc_ff;
      hflags_in = hflags_ff; cmdb_in = cmdb_ff;     bcnt_in = bcnt_ff;
      lits_in = lits_ff;     copy_in = copy_ff;     dist_in = dist_ff;
      term_in = term_ff;     wp_in = wp_ff;
      step_has = 1'b0; step_copy = 1'b0; step_refused = 1'b0; rd_en = 1'b0;
      fail_en = 1'b0; fail_code = rsd_pkg::ST_HDR;
      cmpl_en = 1'b0; eoc_en = 1'b0; eoc_term = term_ff; eoc_prod = produced_ff;
      cb0 = req_in_byte; cb1 = '0; cb2 = '0; cb3 = '0;
      sel_b0 = cmdb_ff[7:0];
      acc_n = {acc_ff[23:0], req_in_byte};
      bc_n  = bcnt_ff + 3'd1;
      fb    = hflags_ff[0] ? 3'd4 : 3'd3;
      hl    = rsd_pkg::hdr_len(hflags_ff);
      len   = rsd_pkg::cmd_len(req_in_byte);
      cons1 = 26'(consumed_ff) + 26'd1;
      if (accept && status_ff == rsd_pkg::ST_RUN) begin
         if (req_cmd) begin
            if (copying) begin
               step_has = 1'b1; step_copy = 1'b1; rd_en = 1'b1;
               wp_in = wp_inc; produced_in = produced_ff + 1'b1;
               copy_in = copy_ff - 11'd1;
            end
         end else if (copying) begin
            step_refused = 1'b1;
         end else if (phase_ff != rsd_pkg::PH_FLAG && consumed_ff >= plen_ff) begin
            fail_en = 1'b1;
            fail_code = (phase_ff == rsd_pkg::PH_CMD || phase_ff == rsd_pkg::PH_CMDMORE ||
                         phase_ff == rsd_pkg::PH_LIT) ? rsd_pkg::ST_TRUNC : rsd_pkg::ST_HDR;
         end else begin
            consumed_in = cons1[24:0];
            case (phase_ff)
               rsd_pkg::PH_FLAG: begin
                  hflags_in = {req_in_byte[7], req_in_byte[0]};
                  if (plen_ff < rsd_pkg::MIN_PACKED ||
                      33'(plen_ff) > 33'(MAX_INPUT_BYTES) ||
                      (req_in_byte & rsd_pkg::FLAG_MASK) != rsd_pkg::FLAG_BASE ||
                      plen_ff <= 25'(rsd_pkg::hdr_len({req_in_byte[7], req_in_byte[0]})))
                  begin
                     fail_en = 1'b1;
                  end else begin
                     phase_in = rsd_pkg::PH_MAGIC;
                  end
               end
               rsd_pkg::PH_MAGIC: begin
                  if (req_in_byte != rsd_pkg::MAGIC_BYTE) begin
                     fail_en = 1'b1;
                  end else begin
                     bcnt_in = '0; acc_in = '0;
                     phase_in = hflags_ff[1] ? rsd_pkg::PH_PSIZE : rsd_pkg::PH_USIZE;
                  end
               end
               rsd_pkg::PH_PSIZE, rsd_pkg::PH_USIZE: begin
                  acc_in = acc_n; bcnt_in = bc_n;
                  if (bc_n >= fb) begin
                     bcnt_in = '0;
                     if (phase_ff == rsd_pkg::PH_PSIZE) begin
                        acc_in = '0;
                        if (acc_n <= 32'(hl) || acc_n > 32'(plen_ff)) fail_en = 1'b1;
                        else phase_in = rsd_pkg::PH_USIZE;
                     end else begin
                        target_in = acc_n[PW-1:0];
                        if (acc_n == 32'd0 || 33'(acc_n) > 33'(MAX_OUTPUT_BYTES)) begin
                           fail_en = 1'b1;
                        end else if (exp_chk_ff && 32'(exp_size_ff) != acc_n) begin
                           fail_en = 1'b1; fail_code = rsd_pkg::ST_SIZE;
                        end else begin
                           phase_in = rsd_pkg::PH_CMD;
                        end
                     end
                  end
               end
               rsd_pkg::PH_CMD: begin
                  if (26'(consumed_ff) + 26'(len) > 26'(plen_ff)) begin
                     fail_en = 1'b1; fail_code = rsd_pkg::ST_TRUNC;
                  end else if (len == 3'd1) begin
                     cmpl_en = 1'b1;
                  end else begin
                     cmdb_in = {16'd0, req_in_byte}; bcnt_in = 3'd1;
                     phase_in = rsd_pkg::PH_CMDMORE;
                  end
               end
               rsd_pkg::PH_CMDMORE: begin
                  case (bcnt_ff)
                     3'd2:    sel_b0 = cmdb_ff[15:8];
                     3'd3:    sel_b0 = cmdb_ff[23:16];
                     default: sel_b0 = cmdb_ff[7:0];
                  endcase
                  len = rsd_pkg::cmd_len(sel_b0);
                  if (bc_n >= len) begin
                     bcnt_in = '0; cmpl_en = 1'b1;
                     case (len)
                        3'd2: begin
                           cb0 = cmdb_ff[7:0]; cb1 = req_in_byte;
                        end
                        3'd3: begin
                           cb0 = cmdb_ff[15:8]; cb1 = cmdb_ff[7:0]; cb2 = req_in_byte;
                        end
                        default: begin
                           cb0 = cmdb_ff[23:16]; cb1 = cmdb_ff[15:8];
                           cb2 = cmdb_ff[7:0];   cb3 = req_in_byte;
                        end
                     endcase
                  end else begin
                     cmdb_in = {cmdb_ff[15:0], req_in_byte}; bcnt_in = bc_n;
                  end
               end
               rsd_pkg::PH_LIT: begin
                  step_has = 1'b1; wp_in = wp_inc;
                  produced_in = produced_ff + 1'b1;
                  lits_in = (lits_ff != 8'd0) ? lits_ff - 8'd1 : lits_ff;
                  if (lits_in == 8'd0) begin
                     eoc_en = 1'b1; eoc_prod = produced_in;
                  end
               end
               default: fail_en = 1'b1;
            endcase
         end
      end
      dec = rsd_pkg::cmd_decode(cb0, cb1, cb2, cb3);
      if (cmpl_en) begin
         if (cons1 + 26'(dec.lits) > 26'(plen_ff)) begin
            fail_en = 1'b1; fail_code = rsd_pkg::ST_TRUNC;
         end else if (33'(produced_ff) + 33'(dec.lits) + 33'(dec.copy) > 33'(target_ff)) begin
            fail_en = 1'b1; fail_code = rsd_pkg::ST_OVER;
         end else if (dec.copy != 11'd0 &&
                      33'(dec.offset) > 33'(produced_ff) + 33'(dec.lits)) begin
            fail_en = 1'b1; fail_code = rsd_pkg::ST_DIST;
         end else begin
            copy_in = dec.copy; dist_in = dec.offset; term_in = dec.term;
            if (dec.lits != 8'd0) begin
               lits_in = dec.lits; phase_in = rsd_pkg::PH_LIT;
            end else begin
               eoc_en = 1'b1; eoc_term = dec.term;
            end
         end
      end
      if (eoc_en) begin
         phase_in = rsd_pkg::PH_CMD;
         if (eoc_term) begin
            copy_in = '0;
            status_in = (eoc_prod == target_ff) ? rsd_pkg::ST_DONE : rsd_pkg::ST_SIZE;
         end else if (cons1 >= 26'(plen_ff)) begin
            fail_en = 1'b1; fail_code = rsd_pkg::ST_TRUNC;
         end
      end
      if (fail_en) begin
         status_in = fail_code; copy_in = '0; lits_in = '0;
      end
   end

   // result fields of the accepted item
   always_comb begin
      step_pend = (status_in == rsd_pkg::ST_RUN) && (phase_in == rsd_pkg::PH_CMD) &&
                  (copy_in != 11'd0);
      if (status_ff != rsd_pkg::ST_RUN) step_status = status_ff;
      else if (step_refused)            step_status = rsd_pkg::ST_REFUSED;
      else                              step_status = status_in;
   end

   assign s1_byte = s1_copy_ff ? (s1_fwd_ff ? s1_fwd_byte_ff : mem_q_ff) : s1_lit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         plen_ff <= '0; exp_chk_ff <= 1'b0; exp_size_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            rsd_pkg::CSR_PACKED_LENGTH:  plen_ff     <= csr_wdata;
            rsd_pkg::CSR_EXPECTED_CHECK: exp_chk_ff  <= csr_wdata[0];
            rsd_pkg::CSR_EXPECTED_SIZE:  exp_size_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= rsd_pkg::PH_FLAG; status_ff <= rsd_pkg::ST_RUN;
         consumed_ff <= '0; produced_ff <= '0; target_ff <= '0; acc_ff <= '0;
         hflags_ff <= '0; cmdb_ff <= '0; bcnt_ff <= '0; lits_ff <= '0;
         copy_ff <= '0; dist_ff <= '0; term_ff <= 1'b0; wp_ff <= '0;
      end else begin
         phase_ff <= phase_in; status_ff <= status_in;
         consumed_ff <= consumed_in; produced_ff <= produced_in; target_ff <= target_in;
         acc_ff <= acc_in; hflags_ff <= hflags_in; cmdb_ff <= cmdb_in; bcnt_ff <= bcnt_in;
         lits_ff <= lits_in; copy_ff <= copy_in; dist_ff <= dist_in; term_ff <= term_in;
         wp_ff <= wp_in;
      end
   end

   // middle stage; s1 always retires at an accept edge
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_has_ff      <= step_has;
         s1_copy_ff     <= step_copy;
         s1_fwd_ff      <= step_copy && s1_valid_ff && s1_has_ff &&
                           (s1_waddr_ff == src_addr);
         s1_fwd_byte_ff <= s1_byte;
         s1_lit_ff      <= req_in_byte;
         s1_waddr_ff    <= wp_ff;
         s1_pend_ff     <= step_pend;
         s1_status_ff   <= step_status;
         s1_cons_ff     <= consumed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && s1_has_ff) hist_mem[s1_waddr_ff] <= s1_byte;
      if (rd_en) mem_q_ff <= hist_mem[src_addr];
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (s1_adv) begin
         rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_has_byte       <= s1_has_ff;
         rsp_out_byte       <= s1_has_ff ? s1_byte : 8'd0;
         rsp_copy_pending   <= s1_pend_ff;
         rsp_status         <= s1_status_ff;
         rsp_bytes_consumed <= s1_cons_ff;
      end
   end

   `RSD_ASSERT(a_status_sticky, clock, reset,
      (status_ff != rsd_pkg::ST_RUN) |=> (status_ff == $past(status_ff)))
   `RSD_ASSERT(a_lit_nonzero, clock, reset,
      (status_ff == rsd_pkg::ST_RUN && phase_ff == rsd_pkg::PH_LIT) |-> (lits_ff != 8'd0))
   `RSD_ASSERT(a_fwd_only_copy, clock, reset,
      (s1_valid_ff && s1_fwd_ff) |-> s1_copy_ff)
   `RSD_NEVER(a_no_overproduce, clock, reset,
      status_ff == rsd_pkg::ST_RUN && produced_ff > target_ff &&
      (phase_ff == rsd_pkg::PH_CMD || phase_ff == rsd_pkg::PH_CMDMORE ||
       phase_ff == rsd_pkg::PH_LIT))

endmodule
`default_nettype wire

// ----- verif/tb.sv -----
// Self-checking testbench for refpack_stream_decompressor: one full compressed stream
// with random content, idling on both channels, and a predictor in a scoreboard class.
// Depends on rsd_pkg and the RTL top level only.
`default_nettype none
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HIST_SIZE   = 131072;
   localparam int MAX_LEN     = 16777216;
   localparam int STALL_LIMIT = 2000;

   typedef struct {
      logic                 has_byte;
      logic [7:0]           out_byte;
      logic                 copy_pending;
      rsd_pkg::status_type  status;
      logic [24:0]          consumed;
   } decomp_out_type;

   typedef struct {
      logic       cmd;
      logic [7:0] data;
   } stream_item_type;

   class decomp_scoreboard;
      int unsigned plen, echk, esize;
      logic [7:0]  hist [HIST_SIZE];
      int unsigned wp, produced, consumed, target, psize, acc, flags;
      rsd_pkg::phase_type  ph;
      int unsigned cbytes, bcnt, lits_left, copy_left, cdist, term_seen;
      rsd_pkg::status_type fst;
      decomp_out_type pending_out[$];
      int          errors;

      function new();
         foreach (hist[i]) hist[i] = 8'd0;
         plen = 0; echk = 0; esize = 0;
         wp = 0; produced = 0; consumed = 0; target = 0; psize = 0; acc = 0;
         flags = 0; ph = rsd_pkg::PH_FLAG; cbytes = 0; bcnt = 0; lits_left = 0;
         copy_left = 0; cdist = 0; term_seen = 0; fst = rsd_pkg::ST_RUN; errors = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [24:0] val);
         case (idx)
            rsd_pkg::CSR_PACKED_LENGTH:  plen = 32'(val);
            rsd_pkg::CSR_EXPECTED_CHECK: echk = 32'(val[0]);
            rsd_pkg::CSR_EXPECTED_SIZE:  esize = 32'(val);
            default: ;
         endcase
      endfunction

      function void stop_with(rsd_pkg::status_type s);
         fst = s;
         copy_left = 0;
         lits_left = 0;
      endfunction

      function int unsigned field_len();
         return flags[0] ? 4 : 3;
      endfunction

      function int unsigned hdr_bytes();
         return 2 + field_len() * (flags[1] ? 2 : 1);
      endfunction

      function int unsigned length_of(int unsigned b0);
         if (b0 < 8'h80) return 2;
         if (b0 < 8'hC0) return 3;
         if (b0 < 8'hE0) return 4;
         return 1;
      endfunction

      function void put_out(int unsigned b);
         hist[wp] = b[7:0];
         wp = (wp + 1) % HIST_SIZE;
         produced++;
      endfunction

      function void command_done();
         ph = rsd_pkg::PH_CMD;
         if (term_seen != 0) begin
            copy_left = 0;
            fst = (produced == target) ? rsd_pkg::ST_DONE : rsd_pkg::ST_SIZE;
         end else if (consumed >= plen) begin
            stop_with(rsd_pkg::ST_TRUNC);
         end
      endfunction

      function void run_command(int unsigned b0, int unsigned b1, int unsigned b2,
                                int unsigned b3);
         int unsigned lits, cp, d;
         bit term;
         d = 0;
         term = 0;
         if (b0 < 8'h80) begin
            lits = b0 & 3;
            cp = ((b0 & 8'h1C) >> 2) + 3;
            d = ((b0 & 8'h60) << 3) + b1 + 1;
         end else if (b0 < 8'hC0) begin
            lits = (b1 >> 6) & 3;
            cp = (b0 & 8'h3F) + 4;
            d = ((b1 & 8'h3F) << 8) + b2 + 1;
         end else if (b0 < 8'hE0) begin
            lits = b0 & 3;
            cp = ((b0 & 8'h0C) << 6) + b3 + 5;
            d = ((b0 & 8'h10) << 12) + (b1 << 8) + b2 + 1;
         end else if (b0 < 8'hFC) begin
            lits = ((b0 & 8'h1F) << 2) + 4;
            cp = 0;
         end else begin
            lits = b0 & 3;
            cp = 0;
            term = 1;
         end
         if (longint'(consumed) + lits > plen) begin
            stop_with(rsd_pkg::ST_TRUNC);
            return;
         end
         if (longint'(produced) + lits + cp > target) begin
            stop_with(rsd_pkg::ST_OVER);
            return;
         end
         if (cp > 0 && d > produced + lits) begin
            stop_with(rsd_pkg::ST_DIST);
            return;
         end
         copy_left = cp;
         cdist = d;
         term_seen = term;
         if (lits > 0) begin
            lits_left = lits;
            ph = rsd_pkg::PH_LIT;
         end else begin
            command_done();
         end
      endfunction

      function void take_byte(int unsigned b, output logic has, output logic [7:0] ob);
         int unsigned pos, len, b0, c;
         has = 0;
         ob = 0;
         pos = consumed;
         if (ph != rsd_pkg::PH_FLAG && pos >= plen) begin
            stop_with(ph < rsd_pkg::PH_CMD ? rsd_pkg::ST_HDR : rsd_pkg::ST_TRUNC);
            return;
         end
         consumed++;
         case (ph)
            rsd_pkg::PH_FLAG: begin
               flags = (b & 1) | ((b & 8'h80) ? 2 : 0);
               if (plen < 5 || plen > MAX_LEN ||
                   (b & rsd_pkg::FLAG_MASK) != rsd_pkg::FLAG_BASE ||
                   plen <= hdr_bytes()) begin
                  stop_with(rsd_pkg::ST_HDR);
                  return;
               end
               ph = rsd_pkg::PH_MAGIC;
            end
            rsd_pkg::PH_MAGIC: begin
               if (b != rsd_pkg::MAGIC_BYTE) begin
                  stop_with(rsd_pkg::ST_HDR);
                  return;
               end
               bcnt = 0;
               acc = 0;
               ph = flags[1] ? rsd_pkg::PH_PSIZE : rsd_pkg::PH_USIZE;
            end
            rsd_pkg::PH_PSIZE, rsd_pkg::PH_USIZE: begin
               acc = (acc << 8) | b;
               bcnt++;
               if (bcnt >= field_len()) begin
                  bcnt = 0;
                  if (ph == rsd_pkg::PH_PSIZE) begin
                     psize = acc;
                     acc = 0;
                     if (psize <= hdr_bytes() || psize > plen) begin
                        stop_with(rsd_pkg::ST_HDR);
                        return;
                     end
                     ph = rsd_pkg::PH_USIZE;
                  end else begin
                     target = acc;
                     if (target == 0 || target > MAX_LEN) begin
                        stop_with(rsd_pkg::ST_HDR);
                        return;
                     end
                     if (echk != 0 && esize != target) begin
                        stop_with(rsd_pkg::ST_SIZE);
                        return;
                     end
                     ph = rsd_pkg::PH_CMD;
                  end
               end
            end
            rsd_pkg::PH_CMD: begin
               len = length_of(b);
               if (longint'(pos) + len > plen) begin
                  stop_with(rsd_pkg::ST_TRUNC);
                  return;
               end
               if (len == 1) begin
                  run_command(b, 0, 0, 0);
               end else begin
                  cbytes = b;
                  bcnt = 1;
                  ph = rsd_pkg::PH_CMDMORE;
               end
            end
            rsd_pkg::PH_CMDMORE: begin
               b0 = (cbytes >> (8 * ((bcnt - 1) & 3))) & 8'hFF;
               len = length_of(b0);
               if (bcnt + 1 >= len) begin
                  c = cbytes;
                  bcnt = 0;
                  if (len == 2) run_command(c & 8'hFF, b, 0, 0);
                  else if (len == 3) run_command((c >> 8) & 8'hFF, c & 8'hFF, b, 0);
                  else run_command((c >> 16) & 8'hFF, (c >> 8) & 8'hFF, c & 8'hFF, b);
               end else begin
                  cbytes = ((cbytes << 8) | b) & 24'hFFFFFF;
                  bcnt++;
               end
            end
            rsd_pkg::PH_LIT: begin
               put_out(b);
               has = 1;
               ob = b[7:0];
               if (lits_left > 0) lits_left--;
               if (lits_left == 0) command_done();
            end
            default: stop_with(rsd_pkg::ST_HDR);
         endcase
      endfunction

      function void note_item(logic cmd, logic [7:0] b);
         decomp_out_type r;
         bit copying;
         int unsigned src;
         copying = (fst == rsd_pkg::ST_RUN && ph == rsd_pkg::PH_CMD && copy_left > 0);
         r.has_byte = 0;
         r.out_byte = 0;
         r.status = fst;
         if (fst == rsd_pkg::ST_RUN) begin
            if (cmd) begin
               if (copying) begin
                  src = (wp + HIST_SIZE - ((cdist % (HIST_SIZE + 1)) % HIST_SIZE)) % HIST_SIZE;
                  r.out_byte = hist[src];
                  r.has_byte = 1;
                  put_out(r.out_byte);
                  copy_left--;
               end
            end else if (copying) begin
               r.status = rsd_pkg::ST_REFUSED;
            end else begin
               take_byte(b, r.has_byte, r.out_byte);
            end
            if (r.status != rsd_pkg::ST_REFUSED) r.status = fst;
         end
         r.copy_pending = (fst == rsd_pkg::ST_RUN && ph == rsd_pkg::PH_CMD && copy_left > 0);
         r.consumed = consumed[24:0];
         pending_out.push_back(r);
      endfunction

      function void check_result(decomp_out_type got);
         decomp_out_type exp_r;
         if (pending_out.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result: status %0d", got.status);
            return;
         end
         exp_r = pending_out.pop_front();
         if (got.has_byte !== exp_r.has_byte || got.out_byte !== exp_r.out_byte ||
             got.copy_pending !== exp_r.copy_pending || got.status !== exp_r.status ||
             got.consumed !== exp_r.consumed) begin
            errors++;
            if (errors <= 10) begin
               $display("mismatch exp has=%0d byte=%02h pend=%0d st=%0d cons=%0d",
                        exp_r.has_byte, exp_r.out_byte, exp_r.copy_pending, exp_r.status,
                        exp_r.consumed);
               $display("         got has=%0d byte=%02h pend=%0d st=%0d cons=%0d",
                        got.has_byte, got.out_byte, got.copy_pending, got.status,
                        got.consumed);
            end
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic        req_cmd = 0;
   logic [7:0]  req_in_byte = 0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic        rsp_has_byte;
   logic [7:0]  rsp_out_byte;
   logic        rsp_copy_pending;
   logic [2:0]  rsp_status;
   logic [24:0] rsp_bytes_consumed;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [1:0]  csr_index = 0;
   logic [24:0] csr_wdata = 0;

   refpack_stream_decompressor dut (
      .clock, .reset, .req_valid, .req_ready, .req_cmd, .req_in_byte,
      .rsp_valid, .rsp_ready, .rsp_has_byte, .rsp_out_byte, .rsp_copy_pending,
      .rsp_status, .rsp_bytes_consumed, .csr_valid, .csr_ready, .csr_index, .csr_wdata
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   decomp_scoreboard sb = new();
   stream_item_type body[$];
   stream_item_type header[$];
   int unsigned  gen_produced;
   bit           calm;
   int           idle_cycles;

   // accepts are judged at the falling edge; inputs only move at the rising edge
   always @(negedge clock) begin
      decomp_out_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.has_byte = rsp_has_byte;
         got.out_byte = rsp_out_byte;
         got.copy_pending = rsp_copy_pending;
         got.status = rsd_pkg::status_type'(rsp_status);
         got.consumed = rsp_bytes_consumed;
         sb.check_result(got);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("FAIL refpack_stream_decompressor");
         $finish;
      end
   end

   initial begin
      int n;
      idle_cycles = 0;
      @(negedge reset);
      forever begin
         n = calm ? 0 : $urandom_range(0, 17);
         if (n > 0) begin
            rsp_ready <= 0;
            repeat (n) @(posedge clock);
         end
         rsp_ready <= 1;
         do @(negedge clock); while (!rsp_valid);
         @(posedge clock);
      end
   end

   task automatic write_csr(logic [1:0] idx, logic [24:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(negedge clock); while (!csr_ready);
      sb.write_reg(idx, val);
      @(posedge clock);
   endtask

   task automatic send_item(stream_item_type it);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_cmd <= it.cmd;
      req_in_byte <= it.data;
      do @(negedge clock); while (!req_ready);
      sb.note_item(it.cmd, it.data);
      @(posedge clock);
   endtask

   task automatic drain_results();
      while (sb.pending_out.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic push_byte(logic cmd, logic [7:0] b);
      stream_item_type it;
      it.cmd = cmd;
      it.data = b;
      body.push_back(it);
   endtask

   task automatic add_literals(int n);
      repeat (n) push_byte(0, 8'($urandom_range(0, 255)));
      gen_produced += n;
   endtask

   task automatic add_copy_ticks(int n);
      repeat (n) begin
         // a byte offered mid-copy is refused and leaves the state alone
         if ($urandom_range(0, 15) == 0) push_byte(0, 8'($urandom_range(0, 255)));
         push_byte(1, 8'($urandom_range(0, 255)));
      end
      gen_produced += n;
   endtask

   // kind: 2, 3 or 4 byte copy command; dist_sel 0 random, 1 shortest, 2 farthest
   task automatic add_copy(int kind, int lits, int dist_sel);
      int cp, maxd, d, dm;
      case (kind)
         2: begin cp = $urandom_range(3, 10); maxd = 1024; end
         3: begin cp = $urandom_range(4, 67); maxd = 16384; end
         default: begin
            cp = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 1028) : $urandom_range(5, 40);
            maxd = HIST_SIZE;
         end
      endcase
      if (gen_produced + lits < maxd) maxd = gen_produced + lits;
      d = (dist_sel == 1) ? 1 : (dist_sel == 2) ? maxd : $urandom_range(1, maxd);
      dm = d - 1;
      case (kind)
         2: begin
            push_byte(0, {1'b0, dm[9:8], 3'(cp - 3), 2'(lits)});
            push_byte(0, dm[7:0]);
         end
         3: begin
            push_byte(0, 8'h80 | 8'(cp - 4));
            push_byte(0, {2'(lits), dm[13:8]});
            push_byte(0, dm[7:0]);
         end
         default: begin
            push_byte(0, {3'b110, dm[16], 2'((cp - 5) >> 8), 2'(lits)});
            push_byte(0, dm[15:8]);
            push_byte(0, dm[7:0]);
            push_byte(0, 8'(cp - 5));
         end
      endcase
      add_literals(lits);
      add_copy_ticks(cp);
   endtask

   task automatic add_literal_run(int k);
      push_byte(0, 8'(8'hE0 + k));
      add_literals(4 * k + 4);
   endtask

   task automatic build_stream();
      int lits, pick;
      gen_produced = 0;
      // directed: shortest literal run, tick with nothing pending, overlapping copies
      add_literal_run(0);
      push_byte(1, 8'hFF);
      add_copy(2, 0, 1);
      add_copy(3, 1, 2);
      add_copy(4, 3, 1);
      while (body.size() < 950) begin
         if ($urandom_range(0, 9) == 0) push_byte(1, 8'($urandom_range(0, 255)));
         pick = $urandom_range(0, 9);
         lits = $urandom_range(0, 3);
         if (pick < 2) add_literal_run($urandom_range(0, 27));
         else if (pick < 5) add_copy(2, lits, $urandom_range(0, 2));
         else if (pick < 8) add_copy(3, lits, $urandom_range(0, 2));
         else add_copy(4, lits, $urandom_range(0, 2));
      end
      lits = $urandom_range(0, 3);
      push_byte(0, 8'(8'hFC + lits));
      add_literals(lits);
   endtask

   task automatic build_header();
      stream_item_type it;
      bit wide, with_psize;
      int fb;
      logic [31:0] psz;
      wide = $urandom_range(0, 1);
      with_psize = $urandom_range(0, 1);
      fb = wide ? 4 : 3;
      psz = wide ? MAX_LEN : 32'hFFFFFF;
      it.cmd = 0;
      it.data = rsd_pkg::FLAG_BASE | (wide ? 8'h01 : 8'h00) | (with_psize ? 8'h80 : 8'h00);
      header.push_back(it);
      it.data = rsd_pkg::MAGIC_BYTE;
      header.push_back(it);
      if (with_psize)
         for (int i = fb - 1; i >= 0; i--) begin
            it.data = 8'(psz >> (8 * i));
            header.push_back(it);
         end
      for (int i = fb - 1; i >= 0; i--) begin
         it.data = 8'(gen_produced >> (8 * i));
         header.push_back(it);
      end
   endtask

   initial begin
      stream_item_type it;
      int count;
      calm = 0;
      build_stream();
      build_header();
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // extremes first, then the working setting before the flag byte
      write_csr(rsd_pkg::CSR_PACKED_LENGTH, 25'd0);
      write_csr(rsd_pkg::CSR_EXPECTED_CHECK, 25'd0);
      write_csr(rsd_pkg::CSR_EXPECTED_SIZE, 25'd0);
      write_csr(rsd_pkg::CSR_PACKED_LENGTH, 25'(MAX_LEN));
      write_csr(rsd_pkg::CSR_EXPECTED_CHECK, 25'd1);
      write_csr(rsd_pkg::CSR_EXPECTED_SIZE, 25'(gen_produced));
      csr_valid <= 0;
      foreach (header[i]) send_item(header[i]);
      count = 0;
      foreach (body[i]) begin
         if (count % 200 == 199) calm = ($urandom_range(0, 2) == 0);
         if (count == body.size() / 2) begin
            req_valid <= 0;
            drain_results();
            write_csr(rsd_pkg::CSR_EXPECTED_CHECK, 25'd0);
            write_csr(rsd_pkg::CSR_EXPECTED_SIZE, 25'(MAX_LEN));
            csr_valid <= 0;
         end
         send_item(body[i]);
         count++;
      end
      req_valid <= 0;
      drain_results();
      // stopped block: further items only repeat the final status
      write_csr(rsd_pkg::CSR_PACKED_LENGTH, 25'd5);
      csr_valid <= 0;
      repeat (8) begin
         it.cmd = 1'($urandom_range(0, 1));
         it.data = 8'($urandom_range(0, 255));
         send_item(it);
      end
      req_valid <= 0;
      drain_results();
      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.pending_out.size() == 0)
         $display("PASS refpack_stream_decompressor");
      else
         $display("FAIL refpack_stream_decompressor");
      $finish;
   end
endmodule
`default_nettype wire
